### design/ptm_pkg.sv
// shared constants, codes and control types for the page table mapper
`timescale 1ns / 1ps

package ptm_pkg;

  localparam int PTM_POOL_PAGES    = 16;
  localparam int PTM_MAX_RUN       = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
  localparam int VPN_W             = 36;
  localparam int PG_SHIFT          = 12;
  localparam int ENTRY_W           = VPN_W + PG_SHIFT;
  localparam int CNT_W             = 7;
  localparam int OFF_W             = 6;
  localparam int ADD_W             = 2;
  localparam int LV_W              = 2;

  localparam logic [PG_SHIFT-1:0] TABLE_FLAGS = 12'h003;
  localparam logic [PG_SHIFT-1:0] LEAF_FLAGS  = 12'h447;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REMAP   = 2'd1,
    ST_NO_POOL = 2'd2,
    ST_PA_ZERO = 2'd3
  } ptm_code_t;

  localparam logic [LV_W-1:0] LV_LEAF = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_PAGE,
    S_READ,
    S_CHECK,
    S_ZERO,
    S_LINK,
    S_EMIT
  } ptm_state_t;

  typedef struct packed {
    logic      load_req;
    logic      page_start;
    logic      set_st;
    ptm_code_t st_code;
    logic      rd;
    logic      sweep_wr;
    logic      sweep_all;
    logic      alloc_link;
    logic      descend;
    logic      write_leaf;
    logic      load_out;
  } ptm_cmd_t;

  typedef struct packed {
    logic pa_zero;
    logic cnt_zero;
    logic lv_last;
    logic rdata_zero;
    logic pool_full;
    logic ptr_bad;
    logic sweep_all_done;
    logic sweep_tbl_done;
    logic run_last;
    logic out_free;
  } ptm_flags_t;

endpackage

### design/ptm_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps

interface ptm_req_if import ptm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VPN_W-1:0] va_start_page;
  logic [VPN_W-1:0] pa_start_page;
  logic [CNT_W-1:0] page_count;

  modport source (output valid, output va_start_page, output pa_start_page,
                  output page_count, input ready);
  modport sink (input valid, input va_start_page, input pa_start_page,
                input page_count, output ready);
endinterface

interface ptm_rsp_if import ptm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] leaf_entry;
  logic [OFF_W-1:0]   page_offset;
  logic [1:0]         status;
  logic [ADD_W-1:0]   tables_added;
  logic               last;

  modport source (output valid, output leaf_entry, output page_offset, output status,
                  output tables_added, output last, input ready);
  modport sink (input valid, input leaf_entry, input page_offset, input status,
                input tables_added, input last, output ready);
endinterface

### design/ptm_ctrl.sv
// control state machine: sequences table walk, allocation, clears and result words
`timescale 1ns / 1ps

module ptm_ctrl import ptm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  ptm_flags_t flags,
  output ptm_cmd_t   cmd
);

  ptm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.sweep_wr  = 1'b1;
        cmd.sweep_all = 1'b1;
        if (flags.sweep_all_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_START;
        end
      end
      S_START: begin
        if (flags.pa_zero) begin
          // rejected request: one word with the zero-address code
          cmd.page_start = 1'b1;
          cmd.set_st     = 1'b1;
          cmd.st_code    = ST_PA_ZERO;
          state_next     = S_EMIT;
        end else if (flags.cnt_zero) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_PAGE;
        end
      end
      S_PAGE: begin
        cmd.page_start = 1'b1;
        state_next     = S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (flags.lv_last) begin
          cmd.write_leaf = 1'b1;
          state_next     = S_EMIT;
        end else if (flags.rdata_zero) begin
          if (flags.pool_full) begin
            cmd.set_st  = 1'b1;
            cmd.st_code = ST_NO_POOL;
            state_next  = S_EMIT;
          end else begin
            state_next = S_ZERO;
          end
        end else if (flags.ptr_bad) begin
          cmd.set_st  = 1'b1;
          cmd.st_code = ST_NO_POOL;
          state_next  = S_EMIT;
        end else begin
          cmd.descend = 1'b1;
          state_next  = S_READ;
        end
      end
      S_ZERO: begin
        // wipe the new table before linking it in
        cmd.sweep_wr = 1'b1;
        if (flags.sweep_tbl_done) state_next = S_LINK;
      end
      S_LINK: begin
        cmd.alloc_link = 1'b1;
        state_next     = S_READ;
      end
      S_EMIT: begin
        if (flags.out_free) begin
          cmd.load_out = 1'b1;
          if (flags.pa_zero || flags.run_last) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_PAGE;
          end
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

### design/ptm_dpath.sv
// datapath: table store, walk registers, bump allocator and result register
`timescale 1ns / 1ps

module ptm_dpath import ptm_pkg::*; #(
  parameter int POOL_PAGES = PTM_POOL_PAGES,
  parameter int MAX_RUN    = PTM_MAX_RUN
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [VPN_W-1:0]   cfg_wr_data,
  input  logic [VPN_W-1:0]   va_start_page,
  input  logic [VPN_W-1:0]   pa_start_page,
  input  logic [CNT_W-1:0]   page_count,
  input  ptm_cmd_t           cmd,
  output ptm_flags_t         flags,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [ENTRY_W-1:0] leaf_entry,
  output logic [OFF_W-1:0]   page_offset,
  output logic [1:0]         status,
  output logic [ADD_W-1:0]   tables_added,
  output logic               last
);

  localparam int TW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int AW    = TW + IDX_W;
  localparam int DEPTH = POOL_PAGES * ENTRIES_PER_TABLE;
  localparam int NFW   = $clog2(POOL_PAGES + 1);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata;

  logic [VPN_W-1:0]   base;
  logic [VPN_W-1:0]   vp;
  logic [VPN_W-1:0]   pp;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   n;
  logic               pa_zero;
  logic [LV_W-1:0]    lv;
  logic [TW-1:0]      tbl;
  logic [NFW-1:0]     next_free;
  logic [ADD_W-1:0]   added;
  ptm_code_t          st;
  logic [ENTRY_W-1:0] leaf;
  logic [AW-1:0]      sweep;

  logic [IDX_W-1:0]   idx;
  logic [AW-1:0]      slot;
  logic [TW-1:0]      nt;
  logic [VPN_W-1:0]   link_page;
  logic [VPN_W-1:0]   t_page;
  logic [AW-1:0]      sweep_addr;
  logic               sweep_done;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               run_last;

  always_comb begin
    case (lv)
      2'd0:    idx = vp[4*IDX_W-1:3*IDX_W];
      2'd1:    idx = vp[3*IDX_W-1:2*IDX_W];
      2'd2:    idx = vp[2*IDX_W-1:IDX_W];
      default: idx = vp[IDX_W-1:0];
    endcase
  end

  assign slot      = {tbl, idx};
  assign nt        = next_free[TW-1:0];
  assign link_page = base + VPN_W'(nt);
  // pool index of the table an entry points at, modulo the page space
  assign t_page    = rdata[ENTRY_W-1:PG_SHIFT] - base;
  assign run_last  = ((n + CNT_W'(1)) == cnt);

  assign sweep_addr = cmd.sweep_all ? sweep : {nt, sweep[IDX_W-1:0]};
  assign sweep_done = cmd.sweep_all ? (sweep == AW'(DEPTH - 1)) : (&sweep[IDX_W-1:0]);

  always_comb begin
    mem_we    = cmd.sweep_wr | cmd.alloc_link | cmd.write_leaf;
    mem_waddr = slot;
    mem_wdata = {pp, LEAF_FLAGS};
    if (cmd.sweep_wr) begin
      mem_waddr = sweep_addr;
      mem_wdata = '0;
    end else if (cmd.alloc_link) begin
      mem_wdata = {link_page, TABLE_FLAGS};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.rd) rdata <= mem[slot];
  end

  always_comb begin
    flags.pa_zero        = pa_zero;
    flags.cnt_zero       = (cnt == '0);
    flags.lv_last        = (lv == LV_LEAF);
    flags.rdata_zero     = (rdata == '0);
    flags.pool_full      = (next_free == NFW'(POOL_PAGES));
    flags.ptr_bad        = (t_page >= VPN_W'(POOL_PAGES));
    flags.sweep_all_done = cmd.sweep_all & sweep_done;
    flags.sweep_tbl_done = ~cmd.sweep_all & sweep_done;
    flags.run_last       = run_last;
    flags.out_free       = ~rsp_valid | rsp_ready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      next_free <= NFW'(1);
      sweep     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) base <= cfg_wr_data;
      if (cmd.alloc_link) next_free <= next_free + NFW'(1);
      if (cmd.sweep_wr) begin
        sweep <= sweep_done ? '0 : sweep + AW'(1);
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      vp      <= va_start_page;
      pp      <= pa_start_page;
      pa_zero <= (pa_start_page == '0);
      cnt     <= (page_count > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : page_count;
      n       <= '0;
    end
    if (cmd.page_start) begin
      lv    <= '0;
      tbl   <= '0;
      added <= '0;
      leaf  <= '0;
    end
    if (cmd.set_st) begin
      st <= cmd.st_code;
    end else if (cmd.page_start) begin
      st <= ST_OK;
    end else if (cmd.write_leaf) begin
      st <= (rdata == '0) ? ST_OK : ST_REMAP;
    end
    if (cmd.descend) begin
      tbl <= t_page[TW-1:0];
      lv  <= lv + LV_W'(1);
    end
    if (cmd.alloc_link) begin
      tbl   <= nt;
      lv    <= lv + LV_W'(1);
      added <= added + ADD_W'(1);
    end
    if (cmd.write_leaf) begin
      leaf <= {pp, LEAF_FLAGS};
    end
    if (cmd.load_out) begin
      leaf_entry   <= leaf;
      page_offset  <= n[OFF_W-1:0];
      status       <= st;
      tables_added <= added;
      last         <= pa_zero | run_last;
      n            <= n + CNT_W'(1);
      vp           <= vp + VPN_W'(1);
      pp           <= pp + VPN_W'(1);
    end
  end

`ifndef NO_ASSERTIONS
  a_alloc_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_link |-> !flags.pool_full)
    else $error("table allocated with pool exhausted");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.sweep_wr, cmd.alloc_link, cmd.write_leaf}))
    else $error("more than one store write source");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten while held");

  a_leaf_status: assert property (@(posedge clk) disable iff (rst)
    cmd.write_leaf |=> (st == ST_OK || st == ST_REMAP))
    else $error("bad status after leaf write");

  a_alloc_from_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_link |-> rdata == '0)
    else $error("link written over a live entry");
`endif

endmodule

### design/page_table_mapper_4level.sv
// top level of the four-level page table mapper
//
//   channel  dir  handshake      words
//   req      in   valid/ready    one per request
//   rsp      out  valid/ready    one per page, or one for a rejected request
//   cfg      in   cfg_wr_en      pool_base_page, no read-back
//
// after reset every entry of the table store is wiped, with req.ready low
// a page walks four dependent store reads, each through a READ and a CHECK state
// an allocation adds ZERO, zeroing the new table one entry a cycle, then LINK
// a rejected request skips the walk; the result register lets the next page run
// while a word waits, and a held word stalls only the following page
`timescale 1ns / 1ps

module page_table_mapper_4level import ptm_pkg::*; #(
  parameter int POOL_PAGES = PTM_POOL_PAGES,
  parameter int MAX_RUN    = PTM_MAX_RUN
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [VPN_W-1:0] cfg_wr_data,
  ptm_req_if.sink          req,
  ptm_rsp_if.source        rsp
);

  ptm_cmd_t   cmd;
  ptm_flags_t flags;

  ptm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  ptm_dpath #(
    .POOL_PAGES (POOL_PAGES),
    .MAX_RUN    (MAX_RUN)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .va_start_page (req.va_start_page),
    .pa_start_page (req.pa_start_page),
    .page_count    (req.page_count),
    .cmd           (cmd),
    .flags         (flags),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .leaf_entry    (rsp.leaf_entry),
    .page_offset   (rsp.page_offset),
    .status        (rsp.status),
    .tables_added  (rsp.tables_added),
    .last          (rsp.last)
  );

endmodule

### tb/tb_page_table_mapper_4level.sv
// self-checking testbench for the four-level page table mapper
`timescale 1ns / 1ps

module tb_page_table_mapper_4level;
  import ptm_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int MIRROR_DEPTH  = PTM_POOL_PAGES * ENTRIES_PER_TABLE;

  typedef struct {
    logic [ENTRY_W-1:0] leaf_entry;
    logic [OFF_W-1:0]   page_offset;
    ptm_code_t          status;
    logic [ADD_W-1:0]   tables_added;
    logic               last;
  } page_word_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en;
  logic [VPN_W-1:0] cfg_wr_data;

  ptm_req_if req ();
  ptm_rsp_if rsp ();

  page_table_mapper_4level u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mirror of the translation tables and the allocator
  bit [63:0]        table_mirror [MIRROR_DEPTH];
  int unsigned      next_table = 1;
  logic [VPN_W-1:0] pool_base  = '0;
  page_word_t       pending_pages [$];

  int mismatches    = 0;
  int requests_sent = 0;
  int words_checked = 0;
  int base_settings = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  // sender pacing
  int burst_left  = 0;
  bit steady_send = 1'b0;

  // receiver stall pattern and long hold-off
  int        hold_asked = 0;
  int        hold_seen  = 0;
  int        hold_left  = 0;
  int        rx_tick    = 0;
  bit [15:0] stall_bits = '0;

  // 512-entry blocks whose level 3 tables get built by the directed cases
  logic [VPN_W-1:0] mapped_blocks [6] = '{
    36'h000000000, 36'h000000200, 36'hFFFFFFE00,
    36'h000001000, 36'h555555400, 36'hAAAAAAA00
  };

  function automatic logic [VPN_W-1:0] rand_page();
    return {4'($urandom), 32'($urandom)};
  endfunction

  // walk the mirror for every page of the run and queue the words it yields
  function automatic void walk_and_map(input logic [VPN_W-1:0] va, input logic [VPN_W-1:0] pa,
                                       input logic [CNT_W-1:0] cnt);
    page_word_t       w;
    logic [VPN_W-1:0] vp, pp, tbl_page;
    logic [8:0]       idx [4];
    bit [63:0]        entry;
    int unsigned      run_len, n, tbl, slot, k;
    int               lv;
    logic [ADD_W-1:0] added;
    ptm_code_t        st;
    if (pa == '0) begin
      w = '{leaf_entry: '0, page_offset: '0, status: ST_PA_ZERO, tables_added: '0, last: 1'b1};
      pending_pages.push_back(w);
      return;
    end
    run_len = (cnt > PTM_MAX_RUN) ? PTM_MAX_RUN : cnt;
    for (n = 0; n < run_len; n++) begin
      vp = va + n;
      pp = pa + n;
      idx[0] = vp[35:27];
      idx[1] = vp[26:18];
      idx[2] = vp[17:9];
      idx[3] = vp[8:0];
      tbl = 0;
      added = '0;
      st = ST_OK;
      for (lv = 0; lv < 3 && st == ST_OK; lv++) begin
        slot = tbl * ENTRIES_PER_TABLE + idx[lv];
        if (table_mirror[slot] == '0) begin
          if (next_table >= PTM_POOL_PAGES) begin
            st = ST_NO_POOL;
          end else begin
            for (k = 0; k < ENTRIES_PER_TABLE; k++)
              table_mirror[next_table * ENTRIES_PER_TABLE + k] = '0;
            table_mirror[slot] = {16'h0, VPN_W'(pool_base + next_table), TABLE_FLAGS};
            next_table++;
            added++;
          end
        end
        if (st == ST_OK) begin
          entry = table_mirror[slot];
          tbl_page = entry[47:12] - pool_base;
          // pointer outside the pool after a base move counts as no pool
          if (tbl_page >= PTM_POOL_PAGES) st = ST_NO_POOL;
          else tbl = 32'(tbl_page);
        end
      end
      w.leaf_entry = '0;
      if (st == ST_OK) begin
        slot = tbl * ENTRIES_PER_TABLE + idx[3];
        if (table_mirror[slot] != '0) st = ST_REMAP;
        w.leaf_entry = {pp, LEAF_FLAGS};
        table_mirror[slot] = {16'h0, w.leaf_entry};
      end
      w.page_offset  = n[OFF_W-1:0];
      w.status       = st;
      w.tables_added = added;
      w.last         = (n + 1 == run_len);
      pending_pages.push_back(w);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // result checker
  page_word_t head_word;
  always @(posedge clk) begin
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_pages.size() == 0) begin
        $error("result word with nothing pending: leaf_entry 0x%0h", rsp.leaf_entry);
        mismatches++;
      end else begin
        head_word = pending_pages.pop_front();
        check_field("leaf_entry", head_word.leaf_entry, rsp.leaf_entry);
        check_field("page_offset", head_word.page_offset, rsp.page_offset);
        check_field("status", head_word.status, rsp.status);
        check_field("tables_added", head_word.tables_added, rsp.tables_added);
        check_field("last", head_word.last, rsp.last);
        status_seen[head_word.status]++;
        words_checked++;
      end
    end
  end

  // receiver: random stalls, calm stretches, and a long hold-off on request
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick[3:0] == 4'd0) stall_bits <= 16'($urandom & $urandom);
    if (hold_seen != hold_asked) begin
      hold_seen <= hold_asked;
      hold_left <= HOLD_CYCLES;
      rsp.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= rx_tick[8] | !stall_bits[rx_tick[3:0]];
    end
  end

  task automatic send_req(input logic [VPN_W-1:0] va, input logic [VPN_W-1:0] pa,
                          input logic [CNT_W-1:0] cnt);
    req.valid         <= 1'b1;
    req.va_start_page <= va;
    req.pa_start_page <= pa;
    req.page_count    <= cnt;
    do @(posedge clk); while (req.ready !== 1'b1);
    walk_and_map(va, pa, cnt);
    requests_sent++;
    if (!steady_send) begin
      if (burst_left == 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40)
                                                 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_pages.size() != 0) @(posedge clk);
    // a zero-count request may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pool_base(input logic [VPN_W-1:0] base);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= base;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pool_base = base;
    base_settings++;
  endtask

  task automatic send_random(input int count);
    int               i, pick;
    logic [VPN_W-1:0] va, pa;
    logic [CNT_W-1:0] cnt;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      va   = mapped_blocks[$urandom_range(0, 5)] + $urandom_range(0, 511);
      pa   = rand_page();
      cnt  = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(9, 64))
                                         : CNT_W'($urandom_range(1, 8));
      if (pick >= 94) begin
        cnt = CNT_W'($urandom_range(65, 127));
      end else if (pick >= 88) begin
        cnt = '0;
      end else if (pick >= 82) begin
        pa  = '0;
        cnt = CNT_W'($urandom_range(0, 127));
      end else if (pick >= 70) begin
        va  = rand_page();
        cnt = CNT_W'($urandom_range(1, 16));
      end
      send_req(va, pa, cnt);
    end
  endtask

  task automatic test_directed_cases();
    set_pool_base('0);
    send_req(36'h000000000, 36'h000000001, 7'd1);    // fresh walk, three tables
    send_req(36'h000000000, 36'h000000005, 7'd1);    // same page again
    send_req(36'h0000001FD, 36'hFFFFFFFFE, 7'd5);    // crosses a table, pa wraps
    send_req(36'hFFFFFFFFF, 36'h000000123, 7'd3);    // va wraps to zero
    send_req(36'h000000040, 36'h000000000, 7'd0);    // zero pa with zero count
    send_req(36'h000000040, 36'h000000000, 7'd127);  // zero pa with full count
    send_req(36'h000000040, 36'h000000800, 7'd0);    // empty run
    send_req(36'h000001000, 36'h0000ABCDE, 7'd127);  // saturates to the max run
    send_req(36'h000001000, 36'h000000077, 7'd64);   // whole run remapped
    send_req(36'h555555555, 36'hAAAAAAAAA, 7'd42);
    send_req(36'hAAAAAAAAA, 36'h555555555, 7'd21);
    send_req(36'h800000000, 36'h000000099, 7'd2);    // pool runs dry mid-walk
    wait_drained();
  endtask

  task automatic test_random_mapping();
    send_random(60);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    int i;
    steady_send = 1'b1;
    hold_asked <= hold_asked + 1;
    for (i = 0; i < 8; i++) send_req(36'(i * 4), rand_page() | 36'h1, 7'd4);
    steady_send = 1'b0;
    wait_drained();
  endtask

  task automatic test_pool_base_moves();
    // top of the range: old pointers land on other pool pages
    set_pool_base(36'hFFFFFFFFF);
    send_random(14);
    wait_drained();
    // far away base: every stored pointer falls outside the pool
    set_pool_base(rand_page() | 36'h040000000);
    send_random(8);
    wait_drained();
    set_pool_base('0);
    send_random(10);
    wait_drained();
  endtask

  initial begin
    req.valid         <= 1'b0;
    req.va_start_page <= '0;
    req.pa_start_page <= '0;
    req.page_count    <= '0;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // table store wipe runs first
    do @(posedge clk); while (req.ready !== 1'b1);

    test_directed_cases();
    test_random_mapping();
    test_output_backpressure();
    test_pool_base_moves();

    $display("covered %0d requests, %0d words over %0d pool base settings",
             requests_sent, words_checked, base_settings);
    $display("status mix: ok %0d, remap %0d, no pool %0d, zero pa %0d",
             status_seen[ST_OK], status_seen[ST_REMAP], status_seen[ST_NO_POOL],
             status_seen[ST_PA_ZERO]);
    if (mismatches == 0) begin
      $display("tb_page_table_mapper_4level: done, clean");
    end else begin
      $display("tb_page_table_mapper_4level: done, errors");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout with %0d words still pending", pending_pages.size());
    $display("tb_page_table_mapper_4level: done, errors");
    $finish;
  end

endmodule

### sim.f
design/ptm_pkg.sv
design/ptm_if.sv
design/ptm_ctrl.sv
design/ptm_dpath.sv
design/page_table_mapper_4level.sv
tb/tb_page_table_mapper_4level.sv
